@@ src/sel_pkg.sv @@
// Shared types and constants for the segment endpoint linker.
// Depends on nothing; imported by every module of the block except sel_ram.
`default_nettype none

package sel_pkg;

    localparam int FIELD_W = 12;
    localparam int IDX_W = 5;
    localparam int THR_W = 16;
    localparam int DIST_CAP = 50000;
    localparam logic [THR_W-1:0] THR_RESET = 16'd1440;

    typedef struct packed {
        logic [FIELD_W-1:0] from_x;
        logic [FIELD_W-1:0] from_y;
        logic [FIELD_W-1:0] to_x;
        logic [FIELD_W-1:0] to_y;
        logic [IDX_W-1:0]   earlier_index;
    } bridge_t;

    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

endpackage

`default_nettype wire

@@ src/sel_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module sel_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/sel_pair_unit.sv @@
// Endpoint pairing pipeline: absolute differences, squares, then the
// four-way minimum with cap and threshold. Depends on sel_pkg.
`default_nettype none

module sel_pair_unit #(
    parameter int CW = 12,
    parameter int AW = 5
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  sel_pkg::tag_t             in_tag,
    input  logic [AW-1:0]             in_idx,
    input  logic [4*CW-1:0]           entry,
    input  logic [4*CW-1:0]           seg,
    input  logic [sel_pkg::THR_W-1:0] threshold,
    output sel_pkg::tag_t             out_tag,
    output logic                      hit,
    output sel_pkg::bridge_t          bridge
);

    import sel_pkg::*;

    localparam int SW = 2 * CW;
    localparam int DW = SW + 1;
    localparam int BW = (DW > 17) ? DW : 17;

    tag_t          tag1_reg, tag2_reg;
    logic [AW-1:0] idx1_reg, idx2_reg;
    logic [4*CW-1:0] e1_reg, e2_reg;
    logic [CW-1:0] dx1_reg [4];
    logic [CW-1:0] dy1_reg [4];
    logic [SW-1:0] sqx2_reg [4];
    logic [SW-1:0] sqy2_reg [4];
    logic [CW-1:0] dx_next [4];
    logic [CW-1:0] dy_next [4];
    logic [1:0]    win;
    logic          found;
    logic [BW-1:0] best;

    always_comb
    begin
        logic [CW-1:0] fx, fy, tx, ty;
        for (int k = 0; k < 4; k++)
        begin
            fx = (k < 2) ? entry[4*CW-1 -: CW] : entry[2*CW-1 -: CW];
            fy = (k < 2) ? entry[3*CW-1 -: CW] : entry[CW-1 -: CW];
            tx = (k % 2 == 1) ? seg[2*CW-1 -: CW] : seg[4*CW-1 -: CW];
            ty = (k % 2 == 1) ? seg[CW-1 -: CW] : seg[3*CW-1 -: CW];
            dx_next[k] = (fx > tx) ? fx - tx : tx - fx;
            dy_next[k] = (fy > ty) ? fy - ty : ty - fy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else if (adv)
        begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx1_reg <= in_idx;
            idx2_reg <= idx1_reg;
            e1_reg   <= entry;
            e2_reg   <= e1_reg;
            for (int k = 0; k < 4; k++)
            begin
                dx1_reg[k]  <= dx_next[k];
                dy1_reg[k]  <= dy_next[k];
                sqx2_reg[k] <= SW'(dx1_reg[k]) * SW'(dx1_reg[k]);
                sqy2_reg[k] <= SW'(dy1_reg[k]) * SW'(dy1_reg[k]);
            end
        end
    end

    always_comb
    begin
        logic [DW-1:0] d;
        best  = BW'(DIST_CAP);
        win   = 2'd0;
        found = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            d = DW'(sqx2_reg[k]) + DW'(sqy2_reg[k]);
            if (BW'(d) < best)
            begin
                best  = BW'(d);
                win   = 2'(k);
                found = 1'b1;
            end
        end
    end

    assign out_tag = tag2_reg;
    assign hit = tag2_reg.valid && found && (best < BW'(threshold));

    always_comb
    begin
        bridge.from_x = FIELD_W'(win[1] ? e2_reg[2*CW-1 -: CW] : e2_reg[4*CW-1 -: CW]);
        bridge.from_y = FIELD_W'(win[1] ? e2_reg[CW-1 -: CW] : e2_reg[3*CW-1 -: CW]);
        bridge.to_x   = FIELD_W'(win[0] ? seg[2*CW-1 -: CW] : seg[4*CW-1 -: CW]);
        bridge.to_y   = FIELD_W'(win[0] ? seg[CW-1 -: CW] : seg[3*CW-1 -: CW]);
        bridge.earlier_index = IDX_W'(idx2_reg);
    end

endmodule

`default_nettype wire

@@ src/segment_endpoint_linker.sv @@
// Top level of the segment endpoint linker: store sequencer and output stage.
// Depends on sel_pkg, sel_ram and sel_pair_unit.
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+------------------------------------------
//  seg      | seg_valid/seg_ready   | first_of_frame, start_x/y, end_x/y
//  bridge   | bridge_valid/_ready   | from_x/y, to_x/y, earlier_index, last_of_run
//  cfg      | cfg_valid/cfg_ready   | cfg_data (distance_threshold)
//
// Each accepted segment is paired with the N > 0 stored segments, which are read one per cycle
// into a three-stage pairing pipeline while it is not held.
// A segment that meets an empty store goes straight to the store write.
// The pipeline holds while a new bridge finds one pending and the output register stalled;
// the last bridge waits for the output register before the store is written.
// Reset empties the store at once; configuration is taken only while the block is idle.
`default_nettype none

module segment_endpoint_linker #(
    parameter int MAX_SEGMENTS = 32,
    parameter int COORD_WIDTH = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        seg_valid,
    output logic                        seg_ready,
    input  logic                        first_of_frame,
    input  logic [sel_pkg::FIELD_W-1:0] start_x,
    input  logic [sel_pkg::FIELD_W-1:0] start_y,
    input  logic [sel_pkg::FIELD_W-1:0] end_x,
    input  logic [sel_pkg::FIELD_W-1:0] end_y,
    output logic                        bridge_valid,
    input  logic                        bridge_ready,
    output logic [sel_pkg::FIELD_W-1:0] from_x,
    output logic [sel_pkg::FIELD_W-1:0] from_y,
    output logic [sel_pkg::FIELD_W-1:0] to_x,
    output logic [sel_pkg::FIELD_W-1:0] to_y,
    output logic [sel_pkg::IDX_W-1:0]   earlier_index,
    output logic                        last_of_run,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sel_pkg::THR_W-1:0]   cfg_data
);

    import sel_pkg::*;

    localparam int CW = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = 4 * CW;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic [CNTW-1:0]  issue_reg, issue_next;
    logic [EW-1:0]    seg_reg, seg_next;
    logic [THR_W-1:0] thresh_reg;
    tag_t             s0_tag_reg, s0_tag_next;
    logic [AW-1:0]    s0_idx_reg, s0_idx_next;
    logic             pend_valid_reg, pend_valid_next;
    bridge_t          pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_last_reg, out_last_next;
    bridge_t          out_reg, out_next;

    logic             adv;
    logic             stall;
    logic             issuing;
    logic             out_free;
    logic             ram_we;
    logic             ram_re;
    logic [EW-1:0]    ram_rdata;
    tag_t             p_tag;
    logic             p_hit;
    bridge_t          p_bridge;

    sel_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SEGMENTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (seg_reg),
        .re    (ram_re),
        .raddr (issue_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    sel_pair_unit #(
        .CW (CW),
        .AW (AW)
    ) u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_tag    (s0_tag_reg),
        .in_idx    (s0_idx_reg),
        .entry     (ram_rdata),
        .seg       (seg_reg),
        .threshold (thresh_reg),
        .out_tag   (p_tag),
        .hit       (p_hit),
        .bridge    (p_bridge)
    );

    assign out_free = !out_valid_reg || bridge_ready;
    assign stall = p_hit && pend_valid_reg && !out_free;
    assign adv = !stall;
    assign issuing = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign ram_re = adv && issuing;
    assign ram_we = (state_reg == ST_FLUSH) && !pend_valid_reg
                    && (count_reg < CNTW'(MAX_SEGMENTS));
    assign seg_ready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !seg_valid;

    always_comb
    begin
        logic [CNTW-1:0] cnt_eff;
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        seg_next        = seg_reg;
        s0_tag_next     = s0_tag_reg;
        s0_idx_next     = s0_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        out_next        = out_reg;
        cnt_eff         = first_of_frame ? '0 : count_reg;

        if (out_valid_reg && bridge_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (adv)
        begin
            s0_tag_next.valid = issuing;
            s0_tag_next.last  = (issue_reg == count_reg - CNTW'(1));
            s0_idx_next       = issue_reg[AW-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (seg_valid)
                begin
                    seg_next   = {CW'(start_x), CW'(start_y), CW'(end_x), CW'(end_y)};
                    count_next = cnt_eff;
                    issue_next = '0;
                    state_next = (cnt_eff == '0) ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (adv)
                begin
                    if (issuing)
                    begin
                        issue_next = issue_reg + CNTW'(1);
                    end
                    if (p_hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = p_bridge;
                        pend_valid_next = 1'b1;
                    end
                    if (p_tag.valid && p_tag.last)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_next        = pend_reg;
                        out_last_next   = 1'b1;
                        out_valid_next  = 1'b1;
                        pend_valid_next = 1'b0;
                    end
                end
                else
                begin
                    if (ram_we)
                    begin
                        count_next = count_reg + CNTW'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            issue_reg      <= '0;
            thresh_reg     <= THR_RESET;
            s0_tag_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            s0_tag_reg     <= s0_tag_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                thresh_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg      <= seg_next;
        s0_idx_reg   <= s0_idx_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign bridge_valid  = out_valid_reg;
    assign from_x        = out_reg.from_x;
    assign from_y        = out_reg.from_y;
    assign to_x          = out_reg.to_x;
    assign to_y          = out_reg.to_y;
    assign earlier_index = out_reg.earlier_index;
    assign last_of_run   = out_last_reg;

endmodule

`default_nettype wire

@@ src/sel_checker.sv @@
// Port-level checks for the segment endpoint linker, bound to its top level.
// Depends on sel_pkg and segment_endpoint_linker.
`default_nettype none

module sel_checker (
    input wire                        clk,
    input wire                        rst_n,
    input wire                        seg_valid,
    input wire                        seg_ready,
    input wire                        bridge_valid,
    input wire                        bridge_ready,
    input wire [sel_pkg::FIELD_W-1:0] from_x,
    input wire [sel_pkg::FIELD_W-1:0] from_y,
    input wire [sel_pkg::FIELD_W-1:0] to_x,
    input wire [sel_pkg::FIELD_W-1:0] to_y,
    input wire [sel_pkg::IDX_W-1:0]   earlier_index,
    input wire                        last_of_run
);

    // A stalled bridge transaction keeps its payload.
    a_bridge_hold: assert property (@(posedge clk) disable iff (!rst_n)
        bridge_valid && !bridge_ready |=> bridge_valid && $stable(from_x)
        && $stable(from_y) && $stable(to_x) && $stable(to_y)
        && $stable(earlier_index) && $stable(last_of_run))
        else $error("bridge payload changed while stalled");

    // A segment is never followed by another one in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid && seg_ready |=> !seg_ready)
        else $error("segment accepted while previous one still in work");

    // A bridge that is not the last of its run means the segment is still in work.
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        bridge_valid && !last_of_run |-> !seg_ready)
        else $error("ready while a run of bridges is still open");

    a_run_open_after: assert property (@(posedge clk) disable iff (!rst_n)
        bridge_valid && bridge_ready && !last_of_run |=> !seg_ready)
        else $error("run closed without a final bridge");

endmodule

bind segment_endpoint_linker sel_checker u_sel_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .seg_valid     (seg_valid),
    .seg_ready     (seg_ready),
    .bridge_valid  (bridge_valid),
    .bridge_ready  (bridge_ready),
    .from_x        (from_x),
    .from_y        (from_y),
    .to_x          (to_x),
    .to_y          (to_y),
    .earlier_index (earlier_index),
    .last_of_run   (last_of_run)
);

`default_nettype wire

@@ test/tb_segment_endpoint_linker.sv @@
// Self-checking testbench for segment_endpoint_linker: random and directed segments,
// an in-bench bridge predictor, random gaps on the segment channel and randomized bridge stalls.
// Depends on sel_pkg and the RTL of the block under test.
module tb_segment_endpoint_linker;
    timeunit 1ns;
    timeprecision 1ps;

    import sel_pkg::*;

    localparam int SEG_SLOTS = 32;
    localparam int COORD_MAX = 4095;
    localparam int SETTLE_CYCLES = 60;
    localparam int QUIET_LIMIT = 4000;

    typedef struct packed {
        logic [FIELD_W-1:0] sx;
        logic [FIELD_W-1:0] sy;
        logic [FIELD_W-1:0] ex;
        logic [FIELD_W-1:0] ey;
    } segment_t;

    typedef struct packed {
        logic     first;
        segment_t seg;
    } seg_txn_t;

    typedef struct packed {
        bridge_t link;
        logic    last;
    } link_txn_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               seg_valid = 1'b0;
    logic               seg_ready;
    logic               first_of_frame = 1'b0;
    logic [FIELD_W-1:0] start_x = '0;
    logic [FIELD_W-1:0] start_y = '0;
    logic [FIELD_W-1:0] end_x = '0;
    logic [FIELD_W-1:0] end_y = '0;
    logic               bridge_valid;
    logic               bridge_ready = 1'b0;
    logic [FIELD_W-1:0] from_x;
    logic [FIELD_W-1:0] from_y;
    logic [FIELD_W-1:0] to_x;
    logic [FIELD_W-1:0] to_y;
    logic [IDX_W-1:0]   earlier_index;
    logic               last_of_run;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [THR_W-1:0]   cfg_data = THR_RESET;

    seg_txn_t  segs_to_send[$];
    link_txn_t expected_links[$];
    int        segs_queued = 0;
    int        segs_accepted = 0;
    int        errors = 0;
    bit        idle_en = 1'b1;

    segment_t         seg_mem[SEG_SLOTS];
    int               seg_count = 0;
    logic [THR_W-1:0] link_threshold = THR_RESET;

    int frame_x[$];
    int frame_y[$];

    segment_endpoint_linker u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .seg_valid     (seg_valid),
        .seg_ready     (seg_ready),
        .first_of_frame(first_of_frame),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .bridge_valid  (bridge_valid),
        .bridge_ready  (bridge_ready),
        .from_x        (from_x),
        .from_y        (from_y),
        .to_x          (to_x),
        .to_y          (to_y),
        .earlier_index (earlier_index),
        .last_of_run   (last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned dist2(input logic [FIELD_W-1:0] ax,
                                          input logic [FIELD_W-1:0] ay,
                                          input logic [FIELD_W-1:0] bx,
                                          input logic [FIELD_W-1:0] by);
        int dx;
        int dy;
        dx = int'(ax) - int'(bx);
        dy = int'(ay) - int'(by);
        return unsigned'(dx * dx + dy * dy);
    endfunction

    function automatic void predict_links(input seg_txn_t t);
        logic [FIELD_W-1:0] fx[4];
        logic [FIELD_W-1:0] fy[4];
        logic [FIELD_W-1:0] tx[4];
        logic [FIELD_W-1:0] ty[4];
        int unsigned        d;
        int unsigned        best;
        int                 win;
        link_txn_t          found[$];
        link_txn_t          lt;
        if (t.first)
        begin
            seg_count = 0;
        end
        for (int j = 0; j < seg_count; j++)
        begin
            fx[0] = seg_mem[j].sx; fy[0] = seg_mem[j].sy; tx[0] = t.seg.sx; ty[0] = t.seg.sy;
            fx[1] = seg_mem[j].sx; fy[1] = seg_mem[j].sy; tx[1] = t.seg.ex; ty[1] = t.seg.ey;
            fx[2] = seg_mem[j].ex; fy[2] = seg_mem[j].ey; tx[2] = t.seg.sx; ty[2] = t.seg.sy;
            fx[3] = seg_mem[j].ex; fy[3] = seg_mem[j].ey; tx[3] = t.seg.ex; ty[3] = t.seg.ey;
            best = DIST_CAP;
            win = -1;
            for (int k = 0; k < 4; k++)
            begin
                d = dist2(fx[k], fy[k], tx[k], ty[k]);
                if (d < best)
                begin
                    best = d;
                    win = k;
                end
            end
            if (win >= 0 && best < link_threshold)
            begin
                lt.link.from_x = fx[win];
                lt.link.from_y = fy[win];
                lt.link.to_x = tx[win];
                lt.link.to_y = ty[win];
                lt.link.earlier_index = j[IDX_W-1:0];
                lt.last = 1'b0;
                found.insert(found.size(), lt);
            end
        end
        if (found.size() > 0)
        begin
            found[found.size() - 1].last = 1'b1;
        end
        foreach (found[i])
        begin
            expected_links.insert(expected_links.size(), found[i]);
        end
        if (seg_count < SEG_SLOTS)
        begin
            seg_mem[seg_count] = t.seg;
            seg_count++;
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    function automatic int jitter(input int c, input int spread);
        int v;
        v = c + int'($urandom_range(2 * spread, 0)) - spread;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > COORD_MAX)
        begin
            v = COORD_MAX;
        end
        return v;
    endfunction

    task automatic add_seg(input bit first, input int sx, input int sy, input int ex, input int ey);
        seg_txn_t t;
        t.first = first;
        t.seg.sx = sx[FIELD_W-1:0];
        t.seg.sy = sy[FIELD_W-1:0];
        t.seg.ex = ex[FIELD_W-1:0];
        t.seg.ey = ey[FIELD_W-1:0];
        if (first)
        begin
            frame_x.delete();
            frame_y.delete();
        end
        frame_x.insert(frame_x.size(), sx);
        frame_y.insert(frame_y.size(), sy);
        frame_x.insert(frame_x.size(), ex);
        frame_y.insert(frame_y.size(), ey);
        segs_to_send.insert(segs_to_send.size(), t);
        segs_queued++;
    endtask

    task automatic gen_frame(input int n, input int near_pct, input int spread);
        int sx;
        int sy;
        int ex;
        int ey;
        int p;
        bit at_start;
        for (int i = 0; i < n; i++)
        begin
            sx = $urandom_range(COORD_MAX, 0);
            sy = $urandom_range(COORD_MAX, 0);
            ex = $urandom_range(COORD_MAX, 0);
            ey = $urandom_range(COORD_MAX, 0);
            if (i > 0 && $urandom_range(99, 0) < near_pct)
            begin
                at_start = 1'($urandom_range(1, 0));
                p = $urandom_range(frame_x.size() - 1, 0);
                if (at_start)
                begin
                    sx = jitter(frame_x[p], spread);
                    sy = jitter(frame_y[p], spread);
                end
                else
                begin
                    ex = jitter(frame_x[p], spread);
                    ey = jitter(frame_y[p], spread);
                end
                if ($urandom_range(1, 0))
                begin
                    p = $urandom_range(frame_x.size() - 1, 0);
                    if (at_start)
                    begin
                        ex = jitter(frame_x[p], spread);
                        ey = jitter(frame_y[p], spread);
                    end
                    else
                    begin
                        sx = jitter(frame_x[p], spread);
                        sy = jitter(frame_y[p], spread);
                    end
                end
            end
            add_seg(i == 0, sx, sy, ex, ey);
        end
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (segs_accepted != segs_queued || expected_links.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        link_threshold = value;
        @(negedge clk);
    endtask

    // Segment driver: one transaction at a time, with random gaps between them.
    always @(posedge clk)
    begin : seg_driver
        static seg_txn_t seg_now;
        static int seg_gap = 0;
        if (rst_n)
        begin
            if (seg_valid && seg_ready)
            begin
                predict_links(seg_now);
                segs_accepted++;
            end
            if (!seg_valid || seg_ready)
            begin
                if (seg_gap > 0)
                begin
                    seg_gap--;
                    seg_valid <= 1'b0;
                end
                else if (segs_to_send.size() > 0)
                begin
                    seg_now = segs_to_send.pop_front();
                    seg_valid <= 1'b1;
                    first_of_frame <= seg_now.first;
                    start_x <= seg_now.seg.sx;
                    start_y <= seg_now.seg.sy;
                    end_x <= seg_now.seg.ex;
                    end_y <= seg_now.seg.ey;
                    if (idle_en && $urandom_range(3, 0) == 0)
                    begin
                        seg_gap = $urandom_range(14, 1);
                    end
                end
                else
                begin
                    seg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : bridge_monitor
        static int stall_left = 0;
        link_txn_t want;
        if (rst_n)
        begin
            if (bridge_valid && bridge_ready)
            begin
                if (expected_links.size() == 0)
                begin
                    $error("unexpected bridge: from (%0d,%0d) to (%0d,%0d) index %0d",
                           from_x, from_y, to_x, to_y, earlier_index);
                    errors++;
                end
                else
                begin
                    want = expected_links.pop_front();
                    check_field("from_x", want.link.from_x, from_x);
                    check_field("from_y", want.link.from_y, from_y);
                    check_field("to_x", want.link.to_x, to_x);
                    check_field("to_y", want.link.to_y, to_y);
                    check_field("earlier_index", want.link.earlier_index, earlier_index);
                    check_field("last_of_run", want.last, last_of_run);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                bridge_ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(7, 0) == 0)
            begin
                stall_left = $urandom_range(13, 0);
                bridge_ready <= 1'b0;
            end
            else
            begin
                bridge_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        static int quiet_cycles = 0;
        if (!rst_n || (seg_valid && seg_ready) || (bridge_valid && bridge_ready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
        begin
            quiet_cycles++;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        add_seg(1, 0, 0, COORD_MAX, COORD_MAX);
        add_seg(0, COORD_MAX, COORD_MAX, 0, 0);
        add_seg(1, 100, 100, 200, 200);
        add_seg(0, 210, 200, 500, 500);
        add_seg(0, 900, 900, 205, 205);
        add_seg(1, 1000, 1000, 1000, 1000);
        add_seg(0, 1010, 1000, 1000, 1010);
        add_seg(1, 2000, 2000, 3000, 3000);
        add_seg(0, 2012, 2036, 3500, 100);
        add_seg(0, 2037, 2008, 100, 3500);
        add_seg(0, COORD_MAX, 0, 0, COORD_MAX);
        add_seg(0, 0, COORD_MAX, COORD_MAX, 0);
        add_seg(0, COORD_MAX, 1, COORD_MAX, COORD_MAX);
        add_seg(1, 300, 300, 600, 600);
        add_seg(0, 1200, 50, 610, 600);

        write_threshold('0);
        gen_frame(10, 90, 20);
        gen_frame(6, 90, 0);

        write_threshold(THR_W'(DIST_CAP));
        gen_frame(34, 70, 150);
        gen_frame(8, 50, 300);

        write_threshold(THR_W'($urandom_range(5000, 200)));
        for (int f = 0; f < 10; f++)
        begin
            gen_frame($urandom_range(12, 1), 80, 40);
        end
        gen_frame(36, 85, 30);

        write_threshold(THR_W'(1));
        gen_frame(12, 80, 0);
        gen_frame(8, 80, 1);

        write_threshold(THR_RESET);
        idle_en = 1'b0;
        for (int f = 0; f < 8; f++)
        begin
            gen_frame($urandom_range(14, 1), 85, 30);
        end

        wait_idle();
        if (errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
